@@ design/kne_pkg.sv @@
// Package for the keypad numeric entry block: status codes, request and
// result types, key layout table and fixed constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kne_pkg;

  localparam int unsigned ValueW = 14;
  localparam int unsigned TickW  = 16;
  localparam int unsigned KeyW   = 7;
  localparam int unsigned CountW = 3;

  localparam logic [ValueW-1:0] VALUE_MAX       = 14'h3FFF;
  localparam logic [TickW-1:0]  TICK_MAX        = 16'hFFFF;
  localparam logic [TickW-1:0]  TIMEOUT_RESET   = 16'd5000;
  localparam logic [KeyW-1:0]   KEY_HASH        = 7'h23;
  localparam logic [KeyW-1:0]   KEY_DELETE      = 7'h44;
  localparam logic [KeyW-1:0]   ASCII_ZERO      = 7'd48;
  localparam logic [KeyW-1:0]   ASCII_NINE      = 7'd57;
  localparam logic [KeyW-1:0]   KEY_NONE        = 7'd0;
  localparam logic [3:0]        DECIMAL_BASE    = 4'd10;
  localparam logic [15:0]       DIV10_RECIP     = 16'd52429;
  localparam int unsigned       DIV10_SHIFT     = 19;

  typedef enum logic [2:0] {
    ST_DIGIT   = 3'd0,
    ST_NONE    = 3'd1,
    ST_DELETE  = 3'd2,
    ST_PROMPT  = 3'd3,
    ST_DONE    = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_e;

  typedef struct packed {
    logic       req_type;
    logic [1:0] key_row;
    logic [1:0] key_col;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [ValueW-1:0]   value;
    logic [CountW-1:0]   digit_count;
    logic [KeyW-1:0]     key_code;
  } rsp_t;

  localparam logic [KeyW-1:0] KEY_TABLE [16] = '{
    7'h37, 7'h38, 7'h39, 7'h41,
    7'h34, 7'h35, 7'h36, 7'h42,
    7'h31, 7'h32, 7'h33, 7'h43,
    7'h2A, 7'h30, 7'h23, 7'h44
  };

  function automatic logic [KeyW-1:0] decode_key(input logic [1:0] row, input logic [1:0] col);
    return KEY_TABLE[{row, col}];
  endfunction

endpackage

`default_nettype wire

@@ design/kne_if.sv @@
// Channel interfaces for the keypad numeric entry block: key/tick requests,
// results and the timeout register write channel. Depends on kne_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface kne_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] key_row;
  logic [1:0] key_col;
  modport source (output valid, req_type, key_row, key_col, input ready);
  modport sink   (input valid, req_type, key_row, key_col, output ready);
endinterface

interface kne_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [kne_pkg::ValueW-1:0]   value;
  logic [kne_pkg::CountW-1:0]   digit_count;
  logic [kne_pkg::KeyW-1:0]     key_code;
  modport source (output valid, status, value, digit_count, key_code, input ready);
  modport sink   (input valid, status, value, digit_count, key_code, output ready);
endinterface

interface kne_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kne_pkg::TickW-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ design/kne_update.sv @@
// Entry state registers and the single-pass update for one request.
// Depends on kne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kne_update #(
  parameter int unsigned MAX_DIGITS = 4,
  parameter int unsigned CntW       = $clog2(MAX_DIGITS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  kne_pkg::req_t               req_i,
  input  logic [kne_pkg::TickW-1:0]   timeout_ticks_i,
  output logic                        emit_o,
  output kne_pkg::rsp_t               rsp_o
);

  logic [kne_pkg::ValueW-1:0] acc_q, acc_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       flag_q, flag_d;
  logic [kne_pkg::TickW-1:0]  idle_q, idle_d;

  logic [kne_pkg::TickW-1:0]  idle_inc;
  logic [kne_pkg::KeyW-1:0]   key;
  logic [kne_pkg::KeyW-1:0]   digit;
  logic [17:0]                appended;
  logic [kne_pkg::ValueW-1:0] appended_sat;
  logic [29:0]                div_prod;
  logic [kne_pkg::ValueW-1:0] quotient;
  logic [CntW+2:0]            cnt_wide;
  logic                       emit;
  kne_pkg::status_e           status;
  logic [kne_pkg::ValueW-1:0] out_value;
  logic [CntW-1:0]            out_cnt;
  logic [kne_pkg::KeyW-1:0]   out_key;

  assign key          = kne_pkg::decode_key(req_i.key_row, req_i.key_col);
  assign digit        = key - kne_pkg::ASCII_ZERO;
  assign appended     = {4'b0, acc_q} * {14'b0, kne_pkg::DECIMAL_BASE} + {11'b0, digit};
  assign appended_sat = (appended > {4'b0, kne_pkg::VALUE_MAX}) ? kne_pkg::VALUE_MAX
                                                                  : appended[13:0];
  assign div_prod     = {16'b0, acc_q} * {14'b0, kne_pkg::DIV10_RECIP};
  assign quotient     = {3'b0, div_prod[29:kne_pkg::DIV10_SHIFT]};
  assign idle_inc     = (idle_q == kne_pkg::TICK_MAX) ? idle_q : idle_q + 16'd1;

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    flag_d    = flag_q;
    idle_d    = '0;
    emit      = 1'b1;
    status    = kne_pkg::ST_NONE;
    out_value = acc_q;
    out_cnt   = cnt_q;
    out_key   = key;
    if (!req_i.req_type) begin
      idle_d  = idle_inc;
      emit    = 1'b0;
      out_key = kne_pkg::KEY_NONE;
      if (idle_inc >= timeout_ticks_i) begin
        acc_d     = '0;
        cnt_d     = '0;
        flag_d    = 1'b0;
        idle_d    = '0;
        emit      = 1'b1;
        status    = kne_pkg::ST_TIMEOUT;
        out_value = '0;
        out_cnt   = '0;
      end
    end else if (key inside {[kne_pkg::ASCII_ZERO:kne_pkg::ASCII_NINE]}) begin
      flag_d = 1'b1;
      if (cnt_q < CntW'(MAX_DIGITS)) begin
        acc_d     = appended_sat;
        cnt_d     = cnt_q + CntW'(1);
        status    = kne_pkg::ST_DIGIT;
        out_value = appended_sat;
        out_cnt   = cnt_q + CntW'(1);
      end
    end else if (key == kne_pkg::KEY_HASH) begin
      if (!flag_q) begin
        status = kne_pkg::ST_PROMPT;
      end else begin
        acc_d  = '0;
        cnt_d  = '0;
        flag_d = 1'b0;
        status = kne_pkg::ST_DONE;
      end
    end else if (key == kne_pkg::KEY_DELETE) begin
      if (cnt_q != '0) begin
        acc_d     = quotient;
        cnt_d     = cnt_q - CntW'(1);
        status    = kne_pkg::ST_DELETE;
        out_value = quotient;
        out_cnt   = cnt_q - CntW'(1);
        if (quotient == '0) begin
          flag_d = 1'b0;
        end
      end
    end
  end

  assign cnt_wide = {3'b0, out_cnt};

  assign emit_o            = emit;
  assign rsp_o.status      = status;
  assign rsp_o.value       = out_value;
  assign rsp_o.digit_count = cnt_wide[2:0];
  assign rsp_o.key_code    = out_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      flag_q <= 1'b0;
      idle_q <= '0;
    end else if (fire_i) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      flag_q <= flag_d;
      idle_q <= idle_d;
    end
  end

endmodule

`default_nettype wire

@@ design/kne_out_reg.sv @@
// Result register driving the result channel; holds a result until taken.
// Depends on kne_pkg and kne_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module kne_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  kne_pkg::rsp_t    data_i,
  output logic             free_o,
  kne_rsp_if.source        rsp_o
);

  logic          valid_q, valid_d;
  kne_pkg::rsp_t data_q;

  assign free_o  = !valid_q || rsp_o.ready;
  assign valid_d = load_i || (valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.status      = data_q.status;
  assign rsp_o.value       = data_q.value;
  assign rsp_o.digit_count = data_q.digit_count;
  assign rsp_o.key_code    = data_q.key_code;

endmodule

`default_nettype wire

@@ design/keypad_numeric_entry.sv @@
// Top level of the keypad numeric entry block: request register, timeout
// register, entry update and result register. Depends on kne_pkg, kne_if,
// kne_update and kne_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Keypad number entry. Each request is a 1 ms idle tick or a key press given
// as row and column (layout 789A / 456B / 123C / *0#D). Digits build a
// decimal number of up to MAX_DIGITS digits, D deletes the last digit, and #
// finishes the entry once a digit was typed (otherwise a prompt status).
// Every key press gives one result; a tick gives one only when the idle count
// reaches timeout_ticks, which ends the entry with a timeout. One request is
// taken every clock cycle unless stalled: the request register feeds a
// single-pass state update into the result register, so the next request
// may follow immediately. The result register holds an untaken result; the
// request side stalls only when both registers are full. timeout_ticks resets
// to 5000; the user must write it through cfg_i while idle (not enforced).
module keypad_numeric_entry #(
  parameter int unsigned MAX_DIGITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kne_cfg_if.sink    cfg_i,
  kne_req_if.sink    req_i,
  kne_rsp_if.source  rsp_o
);

  logic                       in_valid_q, in_valid_d;
  kne_pkg::req_t              in_req_q;
  logic [kne_pkg::TickW-1:0]  timeout_q;
  logic                       req_fire;
  logic                       fire;
  logic                       out_free;
  logic                       emit;
  kne_pkg::rsp_t              rsp;

  assign cfg_i.ready = 1'b1;
  assign fire        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_valid_d  = req_fire || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      timeout_q  <= kne_pkg::TIMEOUT_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_i.valid) begin
        timeout_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_req_q <= '{req_type: req_i.req_type, key_row: req_i.key_row,
                    key_col: req_i.key_col};
    end
  end

  kne_update #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_update (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .req_i           (in_req_q),
    .timeout_ticks_i (timeout_q),
    .emit_o          (emit),
    .rsp_o           (rsp)
  );

  kne_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && emit),
    .data_i (rsp),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

`ifndef SYNTH
  a_timeout_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == kne_pkg::ST_TIMEOUT) |->
      (rsp_o.value == '0) && (rsp_o.digit_count == '0) &&
      (rsp_o.key_code == kne_pkg::KEY_NONE))
    else $error("timeout result carries entry data");

  a_done_on_hash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == kne_pkg::ST_DONE) |->
      (rsp_o.key_code == kne_pkg::KEY_HASH))
    else $error("done result without hash key");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> in_valid_q && rsp_o.valid && !rsp_o.ready)
    else $error("request side stalled with room available");

  a_tick_no_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit && !in_req_q.req_type |=> rsp_o.valid &&
      (rsp_o.status == kne_pkg::ST_TIMEOUT))
    else $error("tick produced a non-timeout result");
`endif

endmodule

`default_nettype wire

@@ sim/keypad_numeric_entry_test.sv @@
// Self-checking testbench for keypad_numeric_entry: a directed table of key presses and
// ticks, short idle runs to the timeout, then random entry sessions under several timeouts.
// Depends on kne_pkg, kne_if and the keypad_numeric_entry RTL.
`timescale 1ns / 1ps

module keypad_numeric_entry_test;
  import kne_pkg::*;

  localparam int unsigned MaxDigits   = 4;
  localparam int unsigned TimeLimit   = 2_000_000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseItems  = 228;

  localparam logic ReqTick = 1'b0;
  localparam logic ReqKey  = 1'b1;

  localparam logic [3:0] PosSeven  = 4'd0;
  localparam logic [3:0] PosThree  = 4'd10;
  localparam logic [3:0] PosZero   = 4'd13;
  localparam logic [3:0] PosHash   = 4'd14;
  localparam logic [3:0] PosDelete = 4'd15;

  localparam logic [TickW-1:0] TimeoutAtReset = 16'd5000;

  localparam logic [KeyW-1:0] Layout [16] = '{
    7'h37, 7'h38, 7'h39, 7'h41,
    7'h34, 7'h35, 7'h36, 7'h42,
    7'h31, 7'h32, 7'h33, 7'h43,
    7'h2A, 7'h30, 7'h23, 7'h44
  };

  typedef struct packed {
    logic              typed;
    logic              kind;
    logic [1:0]        row;
    logic [1:0]        col;
    status_e           st;
    logic [ValueW-1:0] val;
    logic [CountW-1:0] cnt;
    logic [KeyW-1:0]   key;
  } dir_row_t;

  localparam dir_row_t DirTable [26] = '{
    '{1'b1, ReqKey,  2'd3, 2'd2, ST_PROMPT, 14'd0,    3'd0, KEY_HASH},
    '{1'b1, ReqKey,  2'd3, 2'd3, ST_NONE,   14'd0,    3'd0, KEY_DELETE},
    '{1'b0, ReqKey,  2'd0, 2'd3, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd1, 2'd3, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd2, 2'd3, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd3, 2'd0, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqTick, 2'd3, 2'd3, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b1, ReqKey,  2'd0, 2'd2, ST_DIGIT,  14'd9,    3'd1, ASCII_NINE},
    '{1'b1, ReqKey,  2'd0, 2'd2, ST_DIGIT,  14'd99,   3'd2, ASCII_NINE},
    '{1'b1, ReqKey,  2'd0, 2'd2, ST_DIGIT,  14'd999,  3'd3, ASCII_NINE},
    '{1'b1, ReqKey,  2'd0, 2'd2, ST_DIGIT,  14'd9999, 3'd4, ASCII_NINE},
    '{1'b1, ReqKey,  2'd0, 2'd2, ST_NONE,   14'd9999, 3'd4, ASCII_NINE},
    '{1'b1, ReqKey,  2'd3, 2'd3, ST_DELETE, 14'd999,  3'd3, KEY_DELETE},
    '{1'b1, ReqKey,  2'd3, 2'd2, ST_DONE,   14'd999,  3'd3, KEY_HASH},
    '{1'b1, ReqKey,  2'd3, 2'd1, ST_DIGIT,  14'd0,    3'd1, ASCII_ZERO},
    '{1'b1, ReqKey,  2'd3, 2'd2, ST_DONE,   14'd0,    3'd1, KEY_HASH},
    '{1'b1, ReqKey,  2'd3, 2'd1, ST_DIGIT,  14'd0,    3'd1, ASCII_ZERO},
    '{1'b1, ReqKey,  2'd3, 2'd3, ST_DELETE, 14'd0,    3'd0, KEY_DELETE},
    '{1'b1, ReqKey,  2'd3, 2'd2, ST_PROMPT, 14'd0,    3'd0, KEY_HASH},
    '{1'b0, ReqKey,  2'd2, 2'd0, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd2, 2'd1, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd1, 2'd2, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd1, 2'd0, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd1, 2'd1, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd3, 2'd3, ST_NONE,   14'd0,    3'd0, KEY_NONE},
    '{1'b0, ReqKey,  2'd3, 2'd2, ST_NONE,   14'd0,    3'd0, KEY_NONE}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  kne_cfg_if cfg ();
  kne_req_if req ();
  kne_rsp_if rsp ();

  keypad_numeric_entry u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  logic [TickW-1:0]  tmo_ticks;
  logic [TickW-1:0]  idle_ms;
  logic [ValueW-1:0] entry_val;
  logic [CountW-1:0] ndigits;
  logic              have_digit;

  rsp_t        pending [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  function automatic void clear_entry();
    entry_val  = '0;
    ndigits    = '0;
    have_digit = 1'b0;
    idle_ms    = '0;
  endfunction

  function automatic bit advance_entry(input req_t r, output rsp_t res);
    logic [KeyW-1:0] key;
    int unsigned     sum;
    res = '0;
    if (r.req_type == ReqTick) begin
      if (idle_ms != 16'hFFFF) idle_ms++;
      if (idle_ms >= tmo_ticks) begin
        clear_entry();
        res.status   = ST_TIMEOUT;
        res.key_code = KEY_NONE;
        return 1'b1;
      end
      return 1'b0;
    end
    idle_ms      = '0;
    key          = Layout[{r.key_row, r.key_col}];
    res.key_code = key;
    res.status   = ST_NONE;
    if (key >= ASCII_ZERO && key <= ASCII_NINE) begin
      have_digit = 1'b1;
      if (ndigits < MaxDigits) begin
        sum       = entry_val * 10 + (key - ASCII_ZERO);
        entry_val = (sum > VALUE_MAX) ? VALUE_MAX : sum[ValueW-1:0];
        ndigits++;
        res.status = ST_DIGIT;
      end
    end else if (key == KEY_HASH) begin
      if (!have_digit) begin
        res.status = ST_PROMPT;
      end else begin
        res.status      = ST_DONE;
        res.value       = entry_val;
        res.digit_count = ndigits;
        clear_entry();
        return 1'b1;
      end
    end else if (key == KEY_DELETE) begin
      if (ndigits != 0) begin
        entry_val = ValueW'(entry_val / 10);
        ndigits--;
        if (entry_val == 0) have_digit = 1'b0;
        res.status = ST_DELETE;
      end
    end
    res.value       = entry_val;
    res.digit_count = ndigits;
    return 1'b1;
  endfunction

  task automatic send_req(input req_t r, input bit typed, input rsp_t given);
    rsp_t got;
    @(negedge clk_i);
    req.valid    = 1'b1;
    req.req_type = r.req_type;
    req.key_row  = r.key_row;
    req.key_col  = r.key_col;
    do @(posedge clk_i); while (!req.ready);
    if (advance_entry(r, got)) pending.push_back(typed ? given : got);
  endtask

  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      req.valid = 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid = 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [TickW-1:0] ticks);
    drain();
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.data  = ticks;
    do @(posedge clk_i); while (!cfg.ready);
    tmo_ticks = ticks;
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic press(input logic [3:0] pos);
    req_t r;
    r = '{ReqKey, pos[3:2], pos[1:0]};
    send_req(r, 1'b0, '0);
  endtask

  // Tick until the entry times out; the last tick carries a typed expectation.
  task automatic idle_to_timeout(input int unsigned ticks);
    req_t r;
    rsp_t tmo;
    tmo = '{ST_TIMEOUT, 14'd0, 3'd0, KEY_NONE};
    repeat (ticks) begin
      r = '{ReqTick, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
      send_req(r, 1'b0, '0);
    end
    r = '{ReqTick, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
    send_req(r, 1'b1, tmo);
  endtask

  function automatic req_t pick_req();
    req_t        r;
    int unsigned roll;
    int unsigned d;
    r    = '{ReqKey, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
    roll = $urandom_range(0, 99);
    if (roll < 22) begin
      r.req_type = ReqTick;
    end else if (roll < 72) begin
      d = $urandom_range(0, 9);
      if (d == 9) begin
        {r.key_row, r.key_col} = PosZero;
      end else begin
        r.key_row = 2'(d / 3);
        r.key_col = 2'(d % 3);
      end
    end else if (roll < 82) begin
      {r.key_row, r.key_col} = PosDelete;
    end else if (roll < 92) begin
      {r.key_row, r.key_col} = PosHash;
    end
    return r;
  endfunction

  task automatic run_phase(input int unsigned count);
    req_t        r;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap_pct;
    sent    = 0;
    gap_pct = 15;
    while (sent < count) begin
      if ($urandom_range(0, 31) == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 45;
        endcase
      end
      if ($urandom_range(0, 19) == 0) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          r = '{ReqTick, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
          send_req(r, 1'b0, '0);
        end
        sent += burst;
      end else begin
        send_req(pick_req(), 1'b0, '0);
        sent++;
      end
      if (!steady && $urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 6));
      if (!steady && $urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin : result_stalls
    int unsigned stall_pct;
    int unsigned left;
    rsp.ready = 1'b0;
    left      = 0;
    forever begin
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 35;
      endcase
      repeat (64) begin
        @(negedge clk_i);
        if (left == 0 && !steady && $urandom_range(0, 99) < stall_pct) begin
          left = $urandom_range(1, 6);
        end
        if (left != 0) begin
          rsp.ready = 1'b0;
          left--;
        end else begin
          rsp.ready = 1'b1;
        end
      end
    end
  end

  task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual status %0d value %0d count %0d key %0d",
                 $time, rsp.status, rsp.value, rsp.digit_count, rsp.key_code);
      end else begin
        want = pending.pop_front();
        if (rsp.status !== want.status) report("status", want.status, rsp.status);
        if (rsp.value !== want.value) report("value", want.value, rsp.value);
        if (rsp.digit_count !== want.digit_count) begin
          report("digit_count", want.digit_count, rsp.digit_count);
        end
        if (rsp.key_code !== want.key_code) report("key_code", want.key_code, rsp.key_code);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TimeLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    req_t r;
    rsp_t given;
    req.valid    = 1'b0;
    req.req_type = ReqTick;
    req.key_row  = 2'd0;
    req.key_col  = 2'd0;
    cfg.valid    = 1'b0;
    cfg.data     = '0;
    tmo_ticks    = TimeoutAtReset;
    clear_entry();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirTable[i]) begin
      r     = '{DirTable[i].kind, DirTable[i].row, DirTable[i].col};
      given = '{DirTable[i].st, DirTable[i].val, DirTable[i].cnt, DirTable[i].key};
      send_req(r, DirTable[i].typed, given);
    end

    // Idle out a partial entry at a moderate timeout, then at a short one.
    write_timeout(16'd20);
    press(PosSeven);
    idle_to_timeout(19);
    write_timeout(16'd3);
    press(PosThree);
    idle_to_timeout(2);

    write_timeout(16'd0);
    run_phase(PhaseItems);
    write_timeout(16'd1);
    run_phase(PhaseItems);
    write_timeout(16'd2);
    run_phase(PhaseItems);
    write_timeout(16'($urandom_range(3, 12)));
    run_phase(PhaseItems);
    write_timeout(16'($urandom_range(0, 65535)));
    run_phase(PhaseItems);
    write_timeout(16'hFFFF);
    run_phase(PhaseItems);
    write_timeout(16'd5);
    steady = 1'b1;
    run_phase(PhaseItems);

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
